// ===== src/warp_map_position_interpolator_macros.svh =====
// ----------------------------------------------------------------------------
// warp map position interpolator assertion macros
// concurrent assertion shorthands clocked on clk, disabled during reset
// ----------------------------------------------------------------------------
`ifndef WARP_MAP_POSITION_INTERPOLATOR_MACROS_SVH
`define WARP_MAP_POSITION_INTERPOLATOR_MACROS_SVH

// consequent holds in the cycle after the antecedent
`define WMPI_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

// consequent holds in the same cycle as the antecedent
`define WMPI_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

`endif

// ===== src/wmpi_pkg.sv =====
// ----------------------------------------------------------------------------
// wmpi_pkg
// shared widths, types and codes of the warp map position interpolator
// ----------------------------------------------------------------------------
package wmpi_pkg;

	localparam int TL_W        = 31;
	localparam int SRC_W       = 40;
	localparam int OUT_W       = 56;
	localparam int FRAC_W      = 16;
	localparam int CFG_W       = 7;
	localparam int IDX_W       = 6;
	localparam int MAX_ANCHORS = 64;
	localparam int ADDR_W      = (MAX_ANCHORS > 1) ? $clog2(MAX_ANCHORS) : 1;
	localparam int CNT_W       = $clog2(MAX_ANCHORS + 1);
	localparam int ENTRY_W     = TL_W + SRC_W;
	localparam int PROD_W      = TL_W + SRC_W;
	localparam int SRC_LO_W    = SRC_W / 2;
	localparam int SRC_HI_W    = SRC_W - SRC_LO_W;
	localparam int PLO_W       = TL_W + SRC_LO_W;
	localparam int PHI_W       = TL_W + SRC_HI_W;
	localparam int DIV_STEPS   = OUT_W;
	localparam int DIV_CELLS   = 8;
	localparam int RES_CELL    = (DIV_STEPS - 1) % DIV_CELLS;
	localparam int STEP_W      = $clog2(DIV_STEPS);

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FIRST,
		S_LAST,
		S_SEARCH,
		S_LEFT,
		S_RIGHT,
		S_MUL,
		S_DIV,
		S_FIN,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [TL_W-1:0]  rem;
		logic [OUT_W-1:0] bits;
	} div_word_t;

	typedef struct packed {
		logic            start;
		logic [TL_W-1:0] divisor;
		div_word_t       init;
	} div_ctl_t;

endpackage

// ===== src/warp_map_position_interpolator.sv =====
// ----------------------------------------------------------------------------
// warp map position interpolator
// maps a timeline position to a source position through an anchor table
// ----------------------------------------------------------------------------
// input channel (in_valid/in_ready): operation 0 writes one anchor
// (anchor_index, anchor_timeline, anchor_source) in the transfer cycle and
// returns nothing; operation 1 queries query_position and returns one
// source_position in unsigned Q40.16 on the output channel (out_valid/out_ready).
// cfg_we/cfg_wdata set anchor_count, which the user must write only while the
// block is idle; the block does not enforce this. a query runs on one table
// read port: first and last anchor, an upper bound search of up to
// log2(count)+1 reads, two bracket reads, a multiply, and a restoring division
// in the division ring. one item at a time: in_ready is low while a query is
// in progress and is high again in the cycle after its result is loaded.
// the result waits in an output register; a stalled receiver holds it and
// a following query stalls before loading its result. writes are taken
// while a result waits. reset clears anchor_count and the handshake state;
// the table is not cleared and must be written before it is read.
// ----------------------------------------------------------------------------
module warp_map_position_interpolator import wmpi_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CFG_W-1:0]   cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               operation,
	input  logic [IDX_W-1:0]   anchor_index,
	input  logic [TL_W-1:0]    anchor_timeline,
	input  logic [SRC_W-1:0]   anchor_source,
	input  logic [TL_W-1:0]    query_position,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [OUT_W-1:0]   source_position
);

	state_t              state_q, state_d;
	logic [CFG_W-1:0]    anchor_count_q;
	logic [CNT_W-1:0]    cnt;
	logic                out_valid_q;
	logic [OUT_W-1:0]    source_position_q;
	logic                out_load;

	logic [TL_W-1:0]     q_q, q_d;
	logic [TL_W-1:0]     first_t_q, first_t_d;
	logic [CNT_W-1:0]    lo_q, lo_d;
	logic [CNT_W-1:0]    len_q, len_d;
	logic [CNT_W-1:0]    mid_q, mid_d;
	logic [TL_W-1:0]     lt_q, lt_d;
	logic [SRC_W-1:0]    ls_q, ls_d;
	logic [TL_W-1:0]     span_q, span_d;
	logic [TL_W-1:0]     d_q, d_d;
	logic [SRC_W-1:0]    delta_q, delta_d;
	logic                neg_q, neg_d;
	logic [PLO_W-1:0]    p_lo_q, p_lo_d;
	logic [PHI_W-1:0]    p_hi_q, p_hi_d;
	logic [STEP_W-1:0]   step_q, step_d;
	logic [OUT_W-1:0]    res_q, res_d;

	logic                ram_we;
	logic                ram_re;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [ENTRY_W-1:0]  ram_rdata;
	logic [TL_W-1:0]     rd_tl;
	logic [SRC_W-1:0]    rd_src;

	logic [CNT_W-1:0]    half;
	logic [CNT_W-1:0]    lo_n, len_n;
	logic [TL_W-1:0]     qc;
	logic                bad;
	logic [PROD_W-1:0]   prod;
	logic [OUT_W-1:0]    base;
	logic [OUT_W:0]      sum;
	logic [OUT_W:0]      diff;
	logic                inexact;
	div_ctl_t            div_ctl;
	div_word_t           div_res;

	assign cnt = (32'(anchor_count_q) > MAX_ANCHORS) ? CNT_W'(MAX_ANCHORS)
	                                                  : CNT_W'(anchor_count_q);
	assign rd_tl  = ram_rdata[ENTRY_W-1:SRC_W];
	assign rd_src = ram_rdata[SRC_W-1:0];
	assign base   = {ls_q, FRAC_W'(0)};
	assign prod   = {p_hi_q, SRC_LO_W'(0)} + PROD_W'(p_lo_q);

	assign ram_we = (state_q == S_IDLE) && in_valid && (operation == OP_WRITE)
	                && (32'(anchor_index) < MAX_ANCHORS);

	wmpi_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_ANCHORS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ADDR_W'(anchor_index)),
		.wdata ({anchor_timeline, anchor_source}),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign div_ctl.start     = (state_q == S_DIV) && (step_q == '0);
	assign div_ctl.divisor   = span_q;
	assign div_ctl.init.rem  = prod[PROD_W-1 -: TL_W];
	assign div_ctl.init.bits = {prod[SRC_W-1:0], FRAC_W'(0)};

	wmpi_div_ring u_div (
		.clk    (clk),
		.ctl    (div_ctl),
		.result (div_res)
	);

	always_comb begin
		state_d   = state_q;
		q_d       = q_q;
		first_t_d = first_t_q;
		lo_d      = lo_q;
		len_d     = len_q;
		mid_d     = mid_q;
		lt_d      = lt_q;
		ls_d      = ls_q;
		span_d    = span_q;
		d_d       = d_q;
		delta_d   = delta_q;
		neg_d     = neg_q;
		p_lo_d    = p_lo_q;
		p_hi_d    = p_hi_q;
		step_d    = step_q;
		res_d     = res_q;
		ram_re    = 1'b0;
		ram_raddr = '0;
		in_ready  = 1'b0;
		out_load  = 1'b0;
		half      = len_q >> 1;
		lo_n      = lo_q;
		len_n     = len_q;
		qc        = q_q;
		bad       = 1'b0;
		inexact   = |div_res.rem;
		sum       = {1'b0, base} + {1'b0, div_res.bits};
		diff      = {1'b0, base} - {1'b0, div_res.bits} - (OUT_W+1)'(inexact);
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && (operation == OP_QUERY)) begin
					q_d = query_position;
					if (cnt == '0) begin
						res_d   = '0;
						state_d = S_OUT;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = '0;
						state_d   = S_FIRST;
					end
				end
			end
			S_FIRST: begin
				first_t_d = rd_tl;
				ram_re    = 1'b1;
				ram_raddr = ADDR_W'(cnt - CNT_W'(1));
				state_d   = S_LAST;
			end
			S_LAST: begin
				qc        = (q_q > rd_tl) ? rd_tl : q_q;
				qc        = (qc < first_t_q) ? first_t_q : qc;
				q_d       = qc;
				lo_d      = '0;
				len_d     = cnt;
				mid_d     = cnt >> 1;
				ram_re    = 1'b1;
				ram_raddr = ADDR_W'(cnt >> 1);
				state_d   = S_SEARCH;
			end
			S_SEARCH: begin
				if (!(q_q < rd_tl)) begin
					lo_n  = mid_q + CNT_W'(1);
					len_n = len_q - half - CNT_W'(1);
				end else begin
					len_n = half;
				end
				lo_d   = lo_n;
				len_d  = len_n;
				mid_d  = lo_n + (len_n >> 1);
				ram_re = 1'b1;
				if (len_n != '0) begin
					ram_raddr = ADDR_W'(lo_n + (len_n >> 1));
				end else begin
					ram_raddr = (lo_n == '0) ? '0 : ADDR_W'(lo_n - CNT_W'(1));
					state_d   = S_LEFT;
				end
			end
			S_LEFT: begin
				lt_d = rd_tl;
				ls_d = rd_src;
				if ((lo_q == '0) || (lo_q >= cnt)) begin
					res_d   = {rd_src, FRAC_W'(0)};
					state_d = S_OUT;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = ADDR_W'(lo_q);
					state_d   = S_RIGHT;
				end
			end
			S_RIGHT: begin
				bad     = (rd_tl <= lt_q) || (q_q < lt_q)
				          || ((q_q - lt_q) >= (rd_tl - lt_q));
				span_d  = rd_tl - lt_q;
				d_d     = q_q - lt_q;
				neg_d   = rd_src < ls_q;
				delta_d = (rd_src < ls_q) ? (ls_q - rd_src) : (rd_src - ls_q);
				if (bad) begin
					res_d   = base;
					state_d = S_OUT;
				end else begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				p_lo_d  = PLO_W'(d_q) * PLO_W'(delta_q[SRC_LO_W-1:0]);
				p_hi_d  = PHI_W'(d_q) * PHI_W'(delta_q[SRC_W-1:SRC_LO_W]);
				step_d  = '0;
				state_d = S_DIV;
			end
			S_DIV: begin
				step_d = step_q + STEP_W'(1);
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (neg_q) begin
					res_d = diff[OUT_W] ? '0 : diff[OUT_W-1:0];
				end else begin
					res_d = sum[OUT_W] ? '1 : sum[OUT_W-1:0];
				end
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			anchor_count_q <= '0;
			out_valid_q    <= 1'b0;
			step_q         <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			if (cfg_we) begin
				anchor_count_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		q_q       <= q_d;
		first_t_q <= first_t_d;
		lo_q      <= lo_d;
		len_q     <= len_d;
		mid_q     <= mid_d;
		lt_q      <= lt_d;
		ls_q      <= ls_d;
		span_q    <= span_d;
		d_q       <= d_d;
		delta_q   <= delta_d;
		neg_q     <= neg_d;
		p_lo_q    <= p_lo_d;
		p_hi_q    <= p_hi_d;
		res_q     <= res_d;
		if (out_load) begin
			source_position_q <= res_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign source_position = source_position_q;

endmodule

// ===== src/wmpi_ram.sv =====
// ----------------------------------------------------------------------------
// wmpi_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module wmpi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/wmpi_div_cell.sv =====
// ----------------------------------------------------------------------------
// wmpi_div_cell
// one restoring division step, registered toward the next cell
// ----------------------------------------------------------------------------
module wmpi_div_cell import wmpi_pkg::*; (
	input  logic            clk,
	input  logic [TL_W-1:0] divisor,
	input  div_word_t       d_in,
	output div_word_t       d_out
);

	logic [TL_W:0] trial;
	logic          ge;
	div_word_t     step;

	always_comb begin
		trial     = {d_in.rem, d_in.bits[OUT_W-1]};
		ge        = trial >= {1'b0, divisor};
		step.rem  = ge ? TL_W'(trial - {1'b0, divisor}) : TL_W'(trial);
		step.bits = {d_in.bits[OUT_W-2:0], ge};
	end

	always_ff @(posedge clk) begin
		d_out <= step;
	end

endmodule

// ===== src/wmpi_div_ring.sv =====
// ----------------------------------------------------------------------------
// wmpi_div_ring
// ring of division cells; a word laps the ring until all quotient bits are in
// ----------------------------------------------------------------------------
module wmpi_div_ring import wmpi_pkg::*; (
	input  logic      clk,
	input  div_ctl_t  ctl,
	output div_word_t result
);

	div_word_t cell_in  [DIV_CELLS];
	div_word_t cell_out [DIV_CELLS];

	for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign cell_in[i] = ctl.start ? ctl.init : cell_out[DIV_CELLS-1];
		end else begin : g_body
			assign cell_in[i] = cell_out[i-1];
		end
		wmpi_div_cell u_cell (
			.clk     (clk),
			.divisor (ctl.divisor),
			.d_in    (cell_in[i]),
			.d_out   (cell_out[i])
		);
	end

	assign result = cell_out[RES_CELL];

endmodule

// ===== src/wmpi_checker.sv =====
// ----------------------------------------------------------------------------
// wmpi_checker
// port level checks of the warp map position interpolator, bound to the top
// ----------------------------------------------------------------------------
`include "warp_map_position_interpolator_macros.svh"

module wmpi_checker import wmpi_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             operation,
	input logic             out_valid,
	input logic             out_ready,
	input logic [OUT_W-1:0] source_position
);

	// stalled result holds
	`WMPI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(source_position))

	// a query transfer makes the block busy
	`WMPI_ASSERT_NEXT(a_query_busy, in_valid && in_ready && (operation == OP_QUERY), !in_ready)

	// a write transfer leaves the block ready
	`WMPI_ASSERT_NEXT(a_write_ready, in_valid && in_ready && (operation == OP_WRITE), in_ready)

	// a new result is only loaded while a query is in progress
	`WMPI_ASSERT_NOW(a_result_busy, $rose(out_valid), !$past(in_ready))

endmodule

bind warp_map_position_interpolator wmpi_checker u_wmpi_checker (.*);

// ===== dv/warp_map_position_interpolator_tb.sv =====
// ----------------------------------------------------------------------------
// warp_map_position_interpolator_tb
// anchor writes and position queries checked against an in-bench model of the
// piecewise linear lookup; directed corner cases first, then random tables
// and queries with random stalls on both channels
// ----------------------------------------------------------------------------
module warp_map_position_interpolator_tb import wmpi_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_PCT = 13;
	localparam logic [TL_W-1:0] TL_MAX = '1;
	localparam logic [SRC_W-1:0] SRC_MAX = '1;
	localparam logic [OUT_W-1:0] OUT_MAX = '1;

	typedef struct {
		logic             op;
		logic [IDX_W-1:0] index;
		logic [TL_W-1:0]  timeline;
		logic [SRC_W-1:0] source;
		logic [TL_W-1:0]  position;
	} map_item_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [CFG_W-1:0]   cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               operation = OP_WRITE;
	logic [IDX_W-1:0]   anchor_index = '0;
	logic [TL_W-1:0]    anchor_timeline = '0;
	logic [SRC_W-1:0]   anchor_source = '0;
	logic [TL_W-1:0]    query_position = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [OUT_W-1:0]   source_position;

	map_item_t          pending_items[$];
	map_item_t          next_item;
	logic [OUT_W-1:0]   expected_positions[$];
	logic [OUT_W-1:0]   wanted_position;
	logic [TL_W-1:0]    timeline_copy[MAX_ANCHORS];
	logic [SRC_W-1:0]   source_copy[MAX_ANCHORS];
	logic [TL_W-1:0]    planned_timeline[MAX_ANCHORS];
	logic [CFG_W-1:0]   anchor_count_copy = '0;
	int                 idle_pct = IDLE_PCT;
	int                 error_count = 0;
	int                 random_items = 0;

	warp_map_position_interpolator u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.operation       (operation),
		.anchor_index    (anchor_index),
		.anchor_timeline (anchor_timeline),
		.anchor_source   (anchor_source),
		.query_position  (query_position),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.source_position (source_position)
	);

	always #5 clk = ~clk;

	initial begin
		#10_000_000;
		$display("[warp_map_position_interpolator] ERROR");
		$finish;
	end

	function automatic logic [SRC_W-1:0] rand_source();
		logic [63:0] word;
		word = {$urandom(), $urandom()};
		return word[SRC_W-1:0];
	endfunction

	function automatic logic [OUT_W-1:0] interpolate_source(input logic [TL_W-1:0] pos);
		int n, lo, len, half, mid;
		logic [TL_W-1:0] lt, rt, span, d;
		logic [SRC_W-1:0] ls, rs, delta;
		logic [63:0] base, sum, sub;
		logic [95:0] num, frac;
		logic inexact;
		n = (anchor_count_copy > MAX_ANCHORS) ? MAX_ANCHORS : int'(anchor_count_copy);
		if (n == 0)
			return '0;
		if (pos > timeline_copy[n-1])
			pos = timeline_copy[n-1];
		if (pos < timeline_copy[0])
			pos = timeline_copy[0];
		// upper bound search, same probe order as the hardware
		lo = 0;
		len = n;
		while (len > 0) begin
			half = len / 2;
			mid = lo + half;
			if (pos >= timeline_copy[mid]) begin
				lo = mid + 1;
				len = len - half - 1;
			end else begin
				len = half;
			end
		end
		if (lo == 0)
			return {source_copy[0], {FRAC_W{1'b0}}};
		if (lo >= n)
			return {source_copy[n-1], {FRAC_W{1'b0}}};
		lt = timeline_copy[lo-1];
		rt = timeline_copy[lo];
		ls = source_copy[lo-1];
		rs = source_copy[lo];
		base = {8'b0, ls, {FRAC_W{1'b0}}};
		if (rt <= lt || pos < lt || pos - lt >= rt - lt)
			return base[OUT_W-1:0];
		span = rt - lt;
		d = pos - lt;
		delta = (rs >= ls) ? rs - ls : ls - rs;
		num = 96'(d) * 96'(delta);
		num = num << FRAC_W;
		frac = num / 96'(span);
		inexact = (num % 96'(span)) != 0;
		if (rs >= ls) begin
			sum = base + frac[63:0];
			if (sum > 64'(OUT_MAX))
				return OUT_MAX;
			return sum[OUT_W-1:0];
		end
		// falling source: round the drop up so the result stays floored
		sub = frac[63:0] + 64'(inexact);
		if (sub > base)
			return '0;
		sum = base - sub;
		return sum[OUT_W-1:0];
	endfunction

	// driver and input-side prediction
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				if (operation == OP_WRITE) begin
					timeline_copy[anchor_index] = anchor_timeline;
					source_copy[anchor_index] = anchor_source;
				end else begin
					expected_positions = {expected_positions,
						interpolate_source(query_position)};
				end
			end
			if (!in_valid || in_ready) begin
				if (pending_items.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
					next_item = pending_items.pop_front();
					in_valid <= 1'b1;
					operation <= next_item.op;
					anchor_index <= next_item.index;
					anchor_timeline <= next_item.timeline;
					anchor_source <= next_item.source;
					query_position <= next_item.position;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			out_ready <= ($urandom_range(99, 0) >= idle_pct);
			if (out_valid && out_ready) begin
				if (expected_positions.size() == 0) begin
					$display("%0t: source_position %h with none expected", $time,
						source_position);
					error_count++;
				end else begin
					wanted_position = expected_positions.pop_front();
					if (wanted_position !== source_position) begin
						$display("%0t: source_position mismatch, expected %h, actual %h",
							$time, wanted_position, source_position);
						error_count++;
					end
				end
			end
		end
	end

	task automatic push_write(input logic [IDX_W-1:0] index, input logic [TL_W-1:0] timeline,
			input logic [SRC_W-1:0] source);
		map_item_t item;
		item.op = OP_WRITE;
		item.index = index;
		item.timeline = timeline;
		item.source = source;
		item.position = TL_W'($urandom_range(TL_MAX, 0));
		pending_items = {pending_items, item};
	endtask

	task automatic push_query(input logic [TL_W-1:0] position);
		map_item_t item;
		item.op = OP_QUERY;
		item.index = IDX_W'($urandom_range(MAX_ANCHORS - 1, 0));
		item.timeline = TL_W'($urandom_range(TL_MAX, 0));
		item.source = rand_source();
		item.position = position;
		pending_items = {pending_items, item};
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || in_valid || expected_positions.size() != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);
	endtask

	task automatic set_anchor_count(input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		anchor_count_copy = value;
	endtask

	task automatic load_table(input int n);
		longint acc, gap_max;
		int src_mode;
		bit unsorted;
		logic [SRC_W-1:0] src;
		case ($urandom_range(3, 0))
			0: gap_max = 64'(3);
			1: gap_max = 64'(1000);
			2: gap_max = 64'h7FFF_FFFF / 64'(n + 1);
			default: gap_max = 64'($urandom_range(100000, 0));
		endcase
		unsorted = ($urandom_range(9, 0) == 0);
		src_mode = int'($urandom_range(2, 0));
		acc = ($urandom_range(3, 0) == 0) ? 64'(0) : 64'($urandom_range(32'(gap_max), 0));
		src = rand_source();
		for (int i = 0; i < n; i++) begin
			if (unsorted)
				acc = 64'($urandom_range(TL_MAX, 0));
			else if (i > 0)
				acc = acc + 64'($urandom_range(32'(gap_max), 0));
			if (acc > 64'(TL_MAX) || (i == n - 1 && $urandom_range(3, 0) == 0))
				acc = 64'(TL_MAX);
			case (src_mode)
				0: src = rand_source();
				1: src = $urandom_range(1, 0) ? src + SRC_W'($urandom_range(5000, 0))
					: src - SRC_W'($urandom_range(5000, 0));
				default: src = $urandom_range(1, 0) ? SRC_MAX : '0;
			endcase
			planned_timeline[i] = acc[TL_W-1:0];
			push_write(IDX_W'(i), acc[TL_W-1:0], src);
		end
		random_items += n;
	endtask

	function automatic logic [TL_W-1:0] pick_position(input int n);
		logic [TL_W-1:0] lo_t, hi_t;
		if (n == 0)
			return TL_W'($urandom_range(TL_MAX, 0));
		lo_t = planned_timeline[0];
		hi_t = planned_timeline[n-1];
		case ($urandom_range(9, 0))
			0: return planned_timeline[$urandom_range(n - 1, 0)];
			1: return (lo_t == 0) ? '0 : TL_W'($urandom_range(lo_t - 1, 0));
			2: return (hi_t == TL_MAX) ? TL_MAX : TL_W'($urandom_range(TL_MAX, hi_t + 1));
			3: return TL_W'($urandom_range(TL_MAX, 0));
			default: return (lo_t <= hi_t) ? TL_W'($urandom_range(hi_t, lo_t))
				: TL_W'($urandom_range(TL_MAX, 0));
		endcase
	endfunction

	initial begin
		int n_eff, n_queries, phase_no;
		logic [CFG_W-1:0] count_value;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// empty table
		set_anchor_count('0);
		push_query(31'h1234);
		push_write(IDX_W'(0), TL_W'(10), SRC_MAX);
		push_write(IDX_W'(1), TL_W'(13), '0);
		push_write(IDX_W'(2), TL_W'(13), SRC_W'(7));
		push_write(IDX_W'(3), TL_MAX, SRC_MAX);
		push_write(IDX_W'(MAX_ANCHORS - 1), '0, '0);
		wait_drained();

		// single anchor
		set_anchor_count(CFG_W'(1));
		push_query('0);
		push_query(TL_W'(10));
		push_query(TL_MAX);
		wait_drained();

		// falling and rising spans, duplicate timelines, front and end
		set_anchor_count(CFG_W'(4));
		push_query(TL_W'(9));
		push_query(TL_W'(10));
		push_query(TL_W'(11));
		push_query(TL_W'(12));
		push_query(TL_W'(13));
		push_query(TL_W'(14));
		push_query(31'h4000_0000);
		push_query(TL_MAX);
		push_write(IDX_W'(1), TL_W'(5), 40'h12_3456_789A);
		wait_drained();

		// unsorted pair
		set_anchor_count(CFG_W'(2));
		push_query(TL_W'(7));
		push_query(TL_W'(10));

		phase_no = 0;
		while (random_items < 800) begin
			wait_drained();
			idle_pct = (phase_no % 6 == 2) ? 0 : IDLE_PCT;
			if (phase_no == 0)
				count_value = CFG_W'(MAX_ANCHORS);
			else if (phase_no == 1)
				count_value = '1;
			else begin
				case ($urandom_range(19, 0))
					0: count_value = '0;
					1: count_value = CFG_W'(MAX_ANCHORS);
					2: count_value = CFG_W'($urandom_range(127, MAX_ANCHORS + 1));
					3: count_value = CFG_W'(1);
					default: count_value = CFG_W'($urandom_range(8, 2));
				endcase
			end
			set_anchor_count(count_value);
			n_eff = (count_value > MAX_ANCHORS) ? MAX_ANCHORS : int'(count_value);
			load_table(n_eff);
			n_queries = int'($urandom_range(30, 8));
			repeat (n_queries) begin
				if ($urandom_range(11, 0) == 0)
					push_write(IDX_W'($urandom_range(MAX_ANCHORS - 1, 0)),
						TL_W'($urandom_range(TL_MAX, 0)), rand_source());
				else
					push_query(pick_position(n_eff));
			end
			random_items += n_queries;
			phase_no++;
		end
		wait_drained();

		if (error_count == 0)
			$display("[warp_map_position_interpolator] OK");
		else
			$display("[warp_map_position_interpolator] ERROR");
		$finish;
	end

endmodule
